[sv/xds_pkg.sv]
// Shared constants, command word type and decode helpers for the XOR delta trace decoder.
`timescale 1ns / 1ps
package xds_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int HISTORY_DEPTH = 65536;
   localparam int STATE_BYTES   = 65544;
   localparam int REG_AREA      = 8;
   localparam int MEM_SLOTS     = 16;
   localparam int MEM_BYTES     = STATE_BYTES - REG_AREA;
   localparam int QDEPTH        = 4;

   localparam int TW   = $clog2(TABLE_DEPTH);
   localparam int RCW  = $clog2(TABLE_DEPTH + 1);
   localparam int HW   = $clog2(HISTORY_DEPTH);
   localparam int HCW  = $clog2(HISTORY_DEPTH + 1);
   localparam int SAW  = $clog2(MEM_BYTES);
   localparam int MSW  = $clog2(MEM_SLOTS);
   localparam int MAW  = $clog2(TABLE_DEPTH * MEM_SLOTS);
   localparam int QAW  = $clog2(QDEPTH);
   localparam int ENTW = 72;

   // actions on the request side
   localparam logic [2:0] ACT_LOAD   = 3'd0;
   localparam logic [2:0] ACT_APPLY  = 3'd1;
   localparam logic [2:0] ACT_REPLAY = 3'd2;
   localparam logic [2:0] ACT_READ   = 3'd3;
   localparam logic [2:0] ACT_WRITE  = 3'd4;

   // work kinds handed to the back end
   localparam logic [2:0] K_NOP    = 3'd0;
   localparam logic [2:0] K_LOAD   = 3'd1;
   localparam logic [2:0] K_APPLY  = 3'd2;
   localparam logic [2:0] K_REPLAY = 3'd3;
   localparam logic [2:0] K_READ   = 3'd4;
   localparam logic [2:0] K_WRITE  = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_RUN     = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_REGS    = 2'd1;
   localparam logic [1:0] PH_MEMFIX  = 2'd2;
   localparam logic [1:0] PH_MEMZERO = 2'd3;

   typedef struct packed {
      logic [2:0]      kind;
      logic [7:0]      data;
      logic [TW-1:0]   id;
      logic [HW-1:0]   rstart;
      logic [HCW-1:0]  rlen;
      logic [16:0]     sidx;
      logic            mem_we;
      logic [MAW-1:0]  mem_addr;
      logic            rec_we;
      logic [TW-1:0]   slot;
      logic [ENTW-1:0] entry;   // {sizes, regs, header}
      logic [1:0]      status;
      logic            done;
      logic [10:0]     rloaded;
      logic [16:0]     hcount;
   } cmd_type;

   // register bytes a header asks for
   function automatic logic [2:0] reg_need(input logic [7:0] hdr);
      logic [2:0] n;
      n = hdr[0] ? 3'd2 : 3'd0;
      for (int b = 1; b < 6; b++) begin
         n = n + {2'b00, hdr[b]};
      end
      return n;
   endfunction

   // memory triplets stored in a record of the given byte count, capped at sixteen bytes
   function automatic logic [2:0] trip_count(input logic [4:0] msz);
      logic [2:0] t;
      if (msz >= 5'd15) begin
         t = 3'd5;
      end else if (msz >= 5'd12) begin
         t = 3'd4;
      end else if (msz >= 5'd9) begin
         t = 3'd3;
      end else if (msz >= 5'd6) begin
         t = 3'd2;
      end else if (msz >= 5'd3) begin
         t = 3'd1;
      end else begin
         t = 3'd0;
      end
      return t;
   endfunction

endpackage

[sv/xor_delta_state_trace_decoder_core.sv]
// Top level of the XOR delta state trace decoder: front end, command queue and back end.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | contents
//  req     | in        | req_tvalid/tready    | tuser action, tdata operands
//  rsp     | out       | rsp_tvalid/tready    | tdata status and counters
//
//  Once popped from the queue, an apply reads its record through the registered record
//  RAMs and then, for each memory triplet (up to 5 triplets), reads the state RAM and
//  then writes it back. A replay reads each replayed id from the history and does the
//  same for it.
//  Reset clears counters, parse state, queue and back-end control; memories keep
//  their contents. The front end keeps taking words while the queue has room, and
//  a finished result waits in the output register while the next word proceeds.
module xor_delta_state_trace_decoder_core import xds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // action
   input  logic [71:0] req_tdata,   // data_byte, record_id, run_start, run_length, state_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status, read_value, record_done, records_loaded,
                                    // history_count
);
   logic    push, pop, q_full, q_empty;
   cmd_type push_cmd, pop_cmd;

   // accept a word whenever the queue has room; the front end decides all status
   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   xds_front u_front (
      .clock(clock), .reset(reset), .push(push),
      .req_tuser(req_tuser), .req_tdata(req_tdata), .push_cmd(push_cmd)
   );

   // hold classified work until the back end can take it
   xds_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_cmd(push_cmd), .full(q_full),
      .pop(pop), .pop_cmd(pop_cmd), .empty(q_empty)
   );

   // carry out memory work in order and post one result per word
   xds_back u_back (
      .clock(clock), .reset(reset), .empty(q_empty), .pop_cmd(pop_cmd), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule

[sv/xds_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module xds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/xds_front.sv]
// Front end: accepts request words, checks them and tracks counters and record parsing.
`timescale 1ns / 1ps
module xds_front import xds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic [2:0]  req_tuser,
   input  logic [71:0] req_tdata,
   output cmd_type     push_cmd
);
   logic [RCW-1:0] rc_ff, rc_in;
   logic [HCW-1:0] fill_ff, fill_in;
   logic [1:0]     phase_ff, phase_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic [7:0]     hdr_ff, hdr_in;
   logic [55:0]    regs_ff, regs_in;
   logic [7:0]     size_ff, size_in;

   always_comb begin
      cmd_type    c;
      logic [7:0] v;
      logic [4:0] cnt_n;
      logic [1:0] top;
      logic       enter, fin;
      v        = req_tdata[7:0];
      rc_in    = rc_ff;
      fill_in  = fill_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      hdr_in   = hdr_ff;
      regs_in  = regs_ff;
      size_in  = size_ff;
      cnt_n    = cnt_ff + 5'd1;
      enter    = 1'b0;
      fin      = 1'b0;
      c.kind     = K_NOP;
      c.data     = v;
      c.id       = TW'(req_tdata[17:8]);
      c.rstart   = HW'(req_tdata[33:18]);
      c.rlen     = HCW'(req_tdata[50:34]);
      c.sidx     = req_tdata[67:51];
      c.mem_we   = 1'b0;
      c.mem_addr = MAW'({rc_ff[TW-1:0], cnt_ff[MSW-1:0]});
      c.rec_we   = 1'b0;
      c.slot     = rc_ff[TW-1:0];
      c.entry    = '0;
      c.status   = ST_OK;
      c.done     = 1'b0;
      unique case (req_tuser)
         ACT_LOAD: begin
            if (rc_ff >= RCW'(TABLE_DEPTH)) begin
               c.status = ST_FULL;
            end else begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     hdr_in  = v;
                     regs_in = '0;
                     size_in = '0;
                     cnt_in  = '0;
                     if (reg_need(v) != 3'd0) begin
                        phase_in = PH_REGS;
                     end else begin
                        enter = 1'b1;
                     end
                  end
                  PH_REGS: begin
                     regs_in = regs_ff | (56'(v) << {cnt_ff[2:0], 3'b000});
                     cnt_in  = cnt_n;
                     size_in = {5'd0, cnt_n[2:0]};
                     if (cnt_n >= {2'b00, reg_need(hdr_ff)}) begin
                        enter = 1'b1;
                     end
                  end
                  default: begin
                     c.mem_we = 1'b1;
                     cnt_in   = cnt_n;
                     size_in  = {cnt_n, size_ff[2:0]};
                     if (phase_ff == PH_MEMFIX) begin
                        fin = cnt_n >= ((hdr_ff[7:6] == 2'd2) ? 5'd6 : 5'd3);
                     end else begin
                        fin = (v == 8'd0) || (cnt_n >= 5'(MEM_SLOTS));
                     end
                  end
               endcase
               top = hdr_in[7:6];
               if (enter) begin
                  cnt_in = '0;
                  if (top == 2'd3) begin
                     phase_in = PH_MEMZERO;
                  end else if (top == 2'd0) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = PH_MEMFIX;
                  end
               end
               if (fin) begin
                  phase_in = PH_HEADER;
                  cnt_in   = '0;
                  rc_in    = rc_ff + 1'b1;
                  c.done   = 1'b1;
                  c.rec_we = 1'b1;
                  c.entry  = {size_in, regs_in, hdr_in};
               end
               if (c.mem_we || c.rec_we) begin
                  c.kind = K_LOAD;
               end
            end
         end
         ACT_APPLY: begin
            if (RCW'(req_tdata[17:8]) >= rc_ff) begin
               c.status = ST_UNKNOWN;
            end else if (fill_ff >= HCW'(HISTORY_DEPTH)) begin
               c.status = ST_FULL;
            end else begin
               c.kind  = K_APPLY;
               fill_in = fill_ff + 1'b1;
            end
         end
         ACT_REPLAY: begin
            if (c.rlen == '0) begin
               c.kind = K_NOP;
            end else if (HCW'(c.rstart) >= fill_ff) begin
               c.status = ST_RUN;
            end else if (({1'b0, fill_ff} + {1'b0, c.rlen}) > (HCW + 1)'(HISTORY_DEPTH)) begin
               c.status = ST_FULL;
            end else begin
               c.kind  = K_REPLAY;
               fill_in = fill_ff + c.rlen;
            end
         end
         ACT_READ:  c.kind = K_READ;
         ACT_WRITE: c.kind = K_WRITE;
         default:   c.kind = K_NOP;
      endcase
      c.rloaded = 11'(rc_in);
      c.hcount  = 17'(fill_in);
      push_cmd  = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff    <= '0;
         fill_ff  <= '0;
         phase_ff <= PH_HEADER;
         cnt_ff   <= '0;
      end else if (push) begin
         rc_ff    <= rc_in;
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         hdr_ff  <= hdr_in;
         regs_ff <= regs_in;
         size_ff <= size_in;
      end
   end
endmodule

[sv/xds_queue.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module xds_queue import xds_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);
   cmd_type        q_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_cmd;
      end
   end

   assign full    = cnt_ff == (QAW + 1)'(QDEPTH);
   assign empty   = cnt_ff == '0;
   assign pop_cmd = q_ff[rd_ff];
endmodule

[sv/xds_back.sv]
// Back end: runs loads, applies, replays and state accesses against the memories.
`timescale 1ns / 1ps
module xds_back import xds_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  cmd_type     pop_cmd,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata
);
   localparam logic [3:0] B_IDLE  = 4'd0;
   localparam logic [3:0] B_DISP  = 4'd1;
   localparam logic [3:0] B_SWAIT = 4'd2;
   localparam logic [3:0] R_H0    = 4'd3;
   localparam logic [3:0] R_H1    = 4'd4;
   localparam logic [3:0] A_REC   = 4'd5;
   localparam logic [3:0] A_REGS  = 4'd6;
   localparam logic [3:0] B_T0    = 4'd7;
   localparam logic [3:0] B_T1    = 4'd8;
   localparam logic [3:0] B_T2    = 4'd9;
   localparam logic [3:0] B_T3    = 4'd10;
   localparam logic [3:0] B_T4    = 4'd11;
   localparam logic [3:0] A_END   = 4'd12;
   localparam logic [3:0] B_DONE  = 4'd13;

   logic [3:0]     state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [7:0]     regf_ff [REG_AREA];
   logic [7:0]     regf_in [REG_AREA];
   logic [HCW-1:0] hw_ff, hw_in;
   logic [HCW-1:0] i_ff, i_in;
   logic [TW-1:0]  cur_ff, cur_in;
   logic [2:0]     trip_ff, trip_in, ntrip_ff, ntrip_in;
   logic [MSW-1:0] mb_ff, mb_in;
   logic [7:0]     lo_ff, lo_in, hi_ff, hi_in, val_ff, val_in;
   logic [7:0]     rval_ff, rval_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [39:0]    rsp_data_ff, rsp_data_in;

   logic            st_we, hist_we, rec_we, mem_we;
   logic [SAW-1:0]  st_waddr, st_raddr;
   logic [7:0]      st_wdata, st_rdata;
   logic [HW-1:0]   hist_waddr, hist_raddr;
   logic [9:0]      hist_wdata, hist_rdata;
   logic [TW-1:0]   rec_raddr;
   logic [ENTW-1:0] rec_rdata;
   logic [MAW-1:0]  mem_raddr;
   logic [7:0]      mem_rdata;

   xds_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_state (
      .clock(clock), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
      .raddr(st_raddr), .rdata(st_rdata)
   );
   xds_ram #(.WIDTH(10), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock(clock), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
      .raddr(hist_raddr), .rdata(hist_rdata)
   );
   xds_ram #(.WIDTH(ENTW), .DEPTH(TABLE_DEPTH)) u_rec (
      .clock(clock), .we(rec_we), .waddr(cmd_ff.slot), .wdata(cmd_ff.entry),
      .raddr(rec_raddr), .rdata(rec_rdata)
   );
   xds_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH * MEM_SLOTS)) u_rmem (
      .clock(clock), .we(mem_we), .waddr(cmd_ff.mem_addr), .wdata(cmd_ff.data),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   always_comb begin
      logic [2:0] k;
      logic [7:0] hdr;
      logic [55:0] regs;
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      regf_in      = regf_ff;
      hw_in        = hw_ff;
      i_in         = i_ff;
      cur_in       = cur_ff;
      trip_in      = trip_ff;
      ntrip_in     = ntrip_ff;
      mb_in        = mb_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      val_in       = val_ff;
      rval_in      = rval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      st_we        = 1'b0;
      st_waddr     = SAW'(cmd_ff.sidx - 17'(REG_AREA));
      st_wdata     = cmd_ff.data;
      st_raddr     = SAW'(cmd_ff.sidx - 17'(REG_AREA));
      hist_we      = 1'b0;
      hist_waddr   = HW'(hw_ff);
      hist_wdata   = 10'(cmd_ff.id);
      hist_raddr   = HW'(HCW'(cmd_ff.rstart) + i_ff);
      rec_we       = 1'b0;
      rec_raddr    = cur_ff;
      mem_we       = 1'b0;
      mem_raddr    = MAW'({cur_ff, mb_ff});
      hdr          = rec_rdata[7:0];
      regs         = rec_rdata[63:8];
      k            = hdr[0] ? 3'd2 : 3'd0;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               cmd_in   = pop_cmd;
               state_in = B_DISP;
            end
         end
         B_DISP: begin
            rval_in  = 8'd0;
            state_in = B_DONE;
            unique case (cmd_ff.kind) inside
               K_LOAD: begin
                  mem_we = cmd_ff.mem_we;
                  rec_we = cmd_ff.rec_we;
               end
               K_APPLY: begin
                  hist_we  = 1'b1;
                  hw_in    = hw_ff + 1'b1;
                  cur_in   = cmd_ff.id;
                  state_in = A_REC;
               end
               K_REPLAY: begin
                  i_in     = '0;
                  state_in = R_H0;
               end
               K_READ, K_WRITE: begin
                  if (cmd_ff.sidx < 17'(REG_AREA)) begin
                     if (cmd_ff.kind == K_READ) begin
                        rval_in = regf_ff[cmd_ff.sidx[2:0]];
                     end else begin
                        regf_in[cmd_ff.sidx[2:0]] = cmd_ff.data;
                     end
                  end else if (cmd_ff.sidx < 17'(STATE_BYTES)) begin
                     if (cmd_ff.kind == K_READ) begin
                        state_in = B_SWAIT;
                     end else begin
                        st_we = 1'b1;
                     end
                  end
               end
               default: state_in = B_DONE;
            endcase
         end
         B_SWAIT: begin
            rval_in  = st_rdata;
            state_in = B_DONE;
         end
         R_H0: begin
            state_in = R_H1;
         end
         R_H1: begin
            hist_we    = 1'b1;
            hist_wdata = hist_rdata;
            hw_in      = hw_ff + 1'b1;
            i_in       = i_ff + 1'b1;
            cur_in     = TW'(hist_rdata);
            state_in   = (32'(hist_rdata) < TABLE_DEPTH) ? A_REC : A_END;
         end
         A_REC: begin
            state_in = A_REGS;
         end
         A_REGS: begin
            if (hdr[0]) begin
               regf_in[0] = regf_ff[0] ^ regs[7:0];
               regf_in[1] = regf_ff[1] ^ regs[15:8];
            end
            for (int b = 1; b < 6; b++) begin
               if (hdr[b]) begin
                  regf_in[b + 1] = regf_ff[b + 1] ^ regs[{k, 3'b000} +: 8];
                  k = k + 3'd1;
               end
            end
            ntrip_in = trip_count(rec_rdata[71:67]);
            trip_in  = '0;
            mb_in    = '0;
            state_in = (trip_count(rec_rdata[71:67]) == 3'd0) ? A_END : B_T0;
         end
         B_T0: begin
            mb_in    = mb_ff + 1'b1;
            state_in = B_T1;
         end
         B_T1: begin
            lo_in    = mem_rdata;
            mb_in    = mb_ff + 1'b1;
            state_in = B_T2;
         end
         B_T2: begin
            hi_in    = mem_rdata;
            mb_in    = mb_ff + 1'b1;
            state_in = B_T3;
         end
         B_T3: begin
            val_in   = mem_rdata;
            st_raddr = SAW'({hi_ff, lo_ff});
            state_in = B_T4;
         end
         B_T4: begin
            st_we    = 1'b1;
            st_waddr = SAW'({hi_ff, lo_ff});
            st_wdata = st_rdata ^ val_ff;
            trip_in  = trip_ff + 1'b1;
            state_in = ((trip_ff + 3'd1) < ntrip_ff) ? B_T0 : A_END;
         end
         A_END: begin
            state_in = ((cmd_ff.kind == K_REPLAY) && (i_ff < cmd_ff.rlen)) ? R_H0 : B_DONE;
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, cmd_ff.hcount, cmd_ff.rloaded, cmd_ff.done,
                               rval_ff, cmd_ff.status};
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         hw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      regf_ff     <= regf_in;
      i_ff        <= i_in;
      cur_ff      <= cur_in;
      trip_ff     <= trip_in;
      ntrip_ff    <= ntrip_in;
      mb_ff       <= mb_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      val_ff      <= val_in;
      rval_ff     <= rval_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_IDLE) |-> !(st_we || hist_we || rec_we || mem_we))
      else $error("memory write while back end idle");
   a_hist_step: assert property (@(posedge clock) disable iff (reset)
      hist_we |=> (hw_ff == $past(hw_ff) + 1'b1))
      else $error("history pointer did not advance by one");
   a_trip_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_T4) |-> (trip_ff < ntrip_ff))
      else $error("triplet index past record end");
endmodule
